// ===== rtl/spc_pkg.sv =====
// Shared constants, codes and types of the sprite pixel collision block.
// No dependencies; every other file of the block imports this package.
package spc_pkg;

    localparam int MAX_IMAGE_WIDTH  = 128;
    localparam int MAX_IMAGE_HEIGHT = 128;
    localparam int STORE_DEPTH      = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);
    localparam int MAX_DIM          = (MAX_IMAGE_WIDTH > MAX_IMAGE_HEIGHT) ?
                                      MAX_IMAGE_WIDTH : MAX_IMAGE_HEIGHT;
    localparam int CDIM_W           = $clog2(MAX_DIM + 1);

    localparam int PIX_W     = 32;
    localparam int CFG_DIM_W = 8;
    localparam int STRIDE_W  = 7;
    localparam int POS_W     = 12;
    localparam int SIZE_W    = 10;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 7;
    localparam int COORD_W   = 14;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(4);

    typedef enum logic [1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_QUERY  = 2'd2
    } t_mode;

    localparam logic [REG_IDX_W-1:0] REG_A_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_A_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_B_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_KEY_A    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_KEY_B    = 3'd6;

    // Effective configuration: dims saturated to the store, stride never zero
    typedef struct packed {
        logic [CDIM_W-1:0]   a_w;
        logic [CDIM_W-1:0]   a_h;
        logic [CDIM_W-1:0]   b_w;
        logic [CDIM_W-1:0]   b_h;
        logic [STRIDE_W-1:0] step;
        logic [PIX_W-1:0]    key_a;
        logic [PIX_W-1:0]    key_b;
    } t_cfg;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic capture;
        logic setup;
        logic scan;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic done_miss;
    } t_sts;

endpackage

// ===== rtl/spc_cfg_regs.sv =====
// APB-style configuration registers of the sprite collision block.
// Depends on spc_pkg for register indexes and the t_cfg type.
module spc_cfg_regs
    import spc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [CFG_DIM_W-1:0] r_a_w, r_a_h, r_b_w, r_b_h;
    logic [STRIDE_W-1:0]  r_stride;
    logic [PIX_W-1:0]     r_key_a, r_key_b;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_w    <= '0;
            r_a_h    <= '0;
            r_b_w    <= '0;
            r_b_h    <= '0;
            r_stride <= STRIDE_RESET;
            r_key_a  <= '0;
            r_key_b  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_A_WIDTH:  r_a_w    <= pwdata[CFG_DIM_W-1:0];
                REG_A_HEIGHT: r_a_h    <= pwdata[CFG_DIM_W-1:0];
                REG_B_WIDTH:  r_b_w    <= pwdata[CFG_DIM_W-1:0];
                REG_B_HEIGHT: r_b_h    <= pwdata[CFG_DIM_W-1:0];
                REG_STRIDE:   r_stride <= pwdata[STRIDE_W-1:0];
                REG_KEY_A:    r_key_a  <= pwdata;
                REG_KEY_B:    r_key_b  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_A_WIDTH:  prdata = PDATA_W'(r_a_w);
            REG_A_HEIGHT: prdata = PDATA_W'(r_a_h);
            REG_B_WIDTH:  prdata = PDATA_W'(r_b_w);
            REG_B_HEIGHT: prdata = PDATA_W'(r_b_h);
            REG_STRIDE:   prdata = PDATA_W'(r_stride);
            REG_KEY_A:    prdata = r_key_a;
            REG_KEY_B:    prdata = r_key_b;
            default:      prdata = '0;
        endcase
    end

    // saturate to store size
    assign o_cfg.a_w = (int'(r_a_w) > MAX_IMAGE_WIDTH)  ? CDIM_W'(MAX_IMAGE_WIDTH)
                                                        : CDIM_W'(r_a_w);
    assign o_cfg.a_h = (int'(r_a_h) > MAX_IMAGE_HEIGHT) ? CDIM_W'(MAX_IMAGE_HEIGHT)
                                                        : CDIM_W'(r_a_h);
    assign o_cfg.b_w = (int'(r_b_w) > MAX_IMAGE_WIDTH)  ? CDIM_W'(MAX_IMAGE_WIDTH)
                                                        : CDIM_W'(r_b_w);
    assign o_cfg.b_h = (int'(r_b_h) > MAX_IMAGE_HEIGHT) ? CDIM_W'(MAX_IMAGE_HEIGHT)
                                                        : CDIM_W'(r_b_h);
    assign o_cfg.step  = (r_stride == '0) ? STRIDE_W'(1) : r_stride;
    assign o_cfg.key_a = r_key_a;
    assign o_cfg.key_b = r_key_b;

endmodule

// ===== rtl/spc_ctrl.sv =====
// Controller FSM of the sprite collision block: input/output handshake
// and command sequencing. Depends on spc_pkg.
module spc_ctrl
    import spc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_mode,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output logic       o_hit,
    input  logic       i_out_stall,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SETUP  = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_res, n_res;
    logic   r_out_vld, n_out_vld;
    logic   r_out_hit, n_out_hit;
    logic   w_accept;
    logic   w_slot_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_slot_free = !r_out_vld || !i_out_stall;

    assign o_cmd.load_a  = w_accept && (i_mode == MODE_LOAD_A);
    assign o_cmd.load_b  = w_accept && (i_mode == MODE_LOAD_B);
    assign o_cmd.capture = w_accept && (i_mode == MODE_QUERY);
    assign o_cmd.setup   = (r_state == ST_SETUP);
    assign o_cmd.scan    = (r_state == ST_SCAN);

    assign o_out_valid = r_out_vld;
    assign o_hit       = r_out_hit;

    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        n_out_vld = r_out_vld && i_out_stall;
        n_out_hit = r_out_hit;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.hit) begin
                    n_res   = 1'b1;
                    n_state = ST_RESULT;
                end else if (i_sts.done_miss) begin
                    n_res   = 1'b0;
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (w_slot_free) begin
                    n_out_vld = 1'b1;
                    n_out_hit = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res     <= n_res;
        r_out_hit <= n_out_hit;
    end

endmodule

// ===== rtl/spc_datapath.sv =====
// Datapath of the sprite collision block: pixel stores, overlap setup,
// sample scan counters and colour-key compare. Depends on spc_pkg.
module spc_datapath
    import spc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  t_cfg                     i_cfg,
    input  logic [COL_W-1:0]         i_pixel_col,
    input  logic [ROW_W-1:0]         i_pixel_row,
    input  logic [PIX_W-1:0]         i_pixel_color,
    input  logic signed [POS_W-1:0]  i_a_left,
    input  logic signed [POS_W-1:0]  i_a_top,
    input  logic [SIZE_W-1:0]        i_a_rect_width,
    input  logic [SIZE_W-1:0]        i_a_rect_height,
    input  logic signed [POS_W-1:0]  i_b_left,
    input  logic signed [POS_W-1:0]  i_b_top,
    input  logic [SIZE_W-1:0]        i_b_rect_width,
    input  logic [SIZE_W-1:0]        i_b_rect_height,
    output t_sts                     o_sts
);

    logic [PIX_W-1:0] r_mem_a [STORE_DEPTH];
    logic [PIX_W-1:0] r_mem_b [STORE_DEPTH];

    logic signed [POS_W-1:0] r_al, r_at, r_bl, r_bt;
    logic [SIZE_W-1:0]       r_aw, r_ah, r_bw, r_bh;

    logic signed [COORD_W-1:0] w_al, w_at, w_bl, w_bt, w_ar, w_ab, w_br, w_bb;
    logic signed [COORD_W-1:0] w_x1, w_y1, w_x2, w_y2, w_ow, w_oh;

    logic signed [COORD_W-1:0] r_ow, r_oh, r_xa0, r_xb0, r_ya0, r_yb0;
    logic                      r_empty;
    logic signed [COORD_W-1:0] r_x, r_y;

    logic signed [COORD_W-1:0] w_xa, w_xb, w_ya, w_yb, w_step;
    logic signed [COORD_W-1:0] w_aw_lim, w_ah_lim, w_bw_lim, w_bh_lim;
    logic                      w_row_end, w_col_end, w_issue;
    logic [ADDR_W-1:0]         w_ld_addr, w_rd_a, w_rd_b;
    logic                      w_ld_ok;

    logic             r_pend;
    logic [PIX_W-1:0] r_pa, r_pb;

    // loads
    assign w_ld_ok   = (int'(i_pixel_col) < MAX_IMAGE_WIDTH) &&
                       (int'(i_pixel_row) < MAX_IMAGE_HEIGHT);
    assign w_ld_addr = ADDR_W'(int'(i_pixel_row) * MAX_IMAGE_WIDTH + int'(i_pixel_col));

    // query capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_al <= i_a_left;
            r_at <= i_a_top;
            r_aw <= i_a_rect_width;
            r_ah <= i_a_rect_height;
            r_bl <= i_b_left;
            r_bt <= i_b_top;
            r_bw <= i_b_rect_width;
            r_bh <= i_b_rect_height;
        end
    end

    // rectangle intersection
    assign w_al = COORD_W'(r_al);
    assign w_at = COORD_W'(r_at);
    assign w_bl = COORD_W'(r_bl);
    assign w_bt = COORD_W'(r_bt);
    assign w_ar = w_al + signed'(COORD_W'(r_aw));
    assign w_ab = w_at + signed'(COORD_W'(r_ah));
    assign w_br = w_bl + signed'(COORD_W'(r_bw));
    assign w_bb = w_bt + signed'(COORD_W'(r_bh));
    assign w_x1 = (w_al > w_bl) ? w_al : w_bl;
    assign w_y1 = (w_at > w_bt) ? w_at : w_bt;
    assign w_x2 = (w_ar < w_br) ? w_ar : w_br;
    assign w_y2 = (w_ab < w_bb) ? w_ab : w_bb;
    assign w_ow = w_x2 - w_x1;
    assign w_oh = w_y2 - w_y1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_ow    <= w_ow;
            r_oh    <= w_oh;
            r_xa0   <= w_x1 - w_al;
            r_xb0   <= w_x1 - w_bl;
            r_ya0   <= w_y1 - w_at;
            r_yb0   <= w_y1 - w_bt;
            r_empty <= (w_ow <= 0) || (w_oh <= 0) ||
                       (i_cfg.a_w == '0) || (i_cfg.b_w == '0);
        end
    end

    // sample scan
    assign w_step   = COORD_W'(i_cfg.step);
    assign w_aw_lim = COORD_W'(i_cfg.a_w);
    assign w_ah_lim = COORD_W'(i_cfg.a_h);
    assign w_bw_lim = COORD_W'(i_cfg.b_w);
    assign w_bh_lim = COORD_W'(i_cfg.b_h);

    assign w_xa = r_xa0 + r_x;
    assign w_xb = r_xb0 + r_x;
    assign w_ya = r_ya0 + r_y;
    assign w_yb = r_yb0 + r_y;

    // rows only grow, so running past either image's height ends the scan
    assign w_row_end = r_empty || (r_y >= r_oh) || (w_ya >= w_ah_lim) || (w_yb >= w_bh_lim);
    assign w_col_end = (r_x >= r_ow) || (w_xa >= w_aw_lim) || (w_xb >= w_bw_lim);
    assign w_issue   = i_cmd.scan && !w_row_end && !w_col_end;

    assign w_rd_a = ADDR_W'(int'(w_ya) * MAX_IMAGE_WIDTH + int'(w_xa));
    assign w_rd_b = ADDR_W'(int'(w_yb) * MAX_IMAGE_WIDTH + int'(w_xb));

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_x <= '0;
            r_y <= '0;
        end else if (w_issue) begin
            r_x <= r_x + w_step;
        end else if (i_cmd.scan && !w_row_end) begin
            r_x <= '0;
            r_y <= r_y + w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_issue;
        end
    end

    // pixel stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && w_ld_ok) begin
            r_mem_a[w_ld_addr] <= i_pixel_color;
        end
        if (w_issue) begin
            r_pa <= r_mem_a[w_rd_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_b && w_ld_ok) begin
            r_mem_b[w_ld_addr] <= i_pixel_color;
        end
        if (w_issue) begin
            r_pb <= r_mem_b[w_rd_b];
        end
    end

    assign o_sts.hit       = r_pend && (r_pa != i_cfg.key_a) && (r_pb != i_cfg.key_b);
    assign o_sts.done_miss = w_row_end && !r_pend;

endmodule

// ===== rtl/sprite_pixel_collision.sv =====
// Top level of the sprite pixel collision block.
// Instantiates spc_cfg_regs, spc_ctrl and spc_datapath; depends on spc_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_stall): one item per handshake. Mode
//   load A / load B writes i_pixel_color into that sprite's pixel store at
//   (i_pixel_col, i_pixel_row); no result. Mode query carries both screen
//   rectangles and yields one result item; mode 3 is dropped silently.
//   Output channel (o_out_valid / i_out_stall): o_hit, one per query.
//   Config: APB-style, registers at byte address 4*index, pready tied high.
//   Configure only while the block is idle.
// Timing
//   Loads stream at one per cycle while no query holds the input stalled.
//   A query holds the input stalled through setup, through a scan that visits
//   each sample, ends each row and sees the last compare or the end of the
//   scan, reading one sample at a time through each pixel store's read port,
//   and through placing the result in the output register.
//   The result sits in an output register, so the next item is taken while
//   it waits.
// Reset and stall
//   Reset clears the registers (stride 4, all else 0) and the control state;
//   store contents stay undefined until loaded, no clearing pass. While the
//   receiver stalls, o_hit holds; a further query finishes its scan and then
//   waits for the output register before accepting more items.
module sprite_pixel_collision
    import spc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_mode,
    input  logic [COL_W-1:0]        i_pixel_col,
    input  logic [ROW_W-1:0]        i_pixel_row,
    input  logic [PIX_W-1:0]        i_pixel_color,
    input  logic signed [POS_W-1:0] i_a_left,
    input  logic signed [POS_W-1:0] i_a_top,
    input  logic [SIZE_W-1:0]       i_a_rect_width,
    input  logic [SIZE_W-1:0]       i_a_rect_height,
    input  logic signed [POS_W-1:0] i_b_left,
    input  logic signed [POS_W-1:0] i_b_top,
    input  logic [SIZE_W-1:0]       i_b_rect_width,
    input  logic [SIZE_W-1:0]       i_b_rect_height,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_hit,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // config registers; outputs already saturated and stride-fixed
    spc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer: idle -> setup -> scan -> result
    spc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_hit       (o_hit),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // stores, overlap arithmetic, scan counters, key compare
    spc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg           (w_cfg),
        .i_pixel_col     (i_pixel_col),
        .i_pixel_row     (i_pixel_row),
        .i_pixel_color   (i_pixel_color),
        .i_a_left        (i_a_left),
        .i_a_top         (i_a_top),
        .i_a_rect_width  (i_a_rect_width),
        .i_a_rect_height (i_a_rect_height),
        .i_b_left        (i_b_left),
        .i_b_top         (i_b_top),
        .i_b_rect_width  (i_b_rect_width),
        .i_b_rect_height (i_b_rect_height),
        .o_sts           (w_sts)
    );

    // an accepted query always moves straight into setup
    a_query_to_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_mode == MODE_QUERY)) |=> w_cmd.setup)
        else $error("query accepted but setup not started");

    // the scan follows setup in the next cycle
    a_setup_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.setup |=> w_cmd.scan)
        else $error("setup not followed by scan");

    // a hit can only come from a read issued during the scan
    a_hit_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.hit |-> $past(w_cmd.scan))
        else $error("hit flagged without a scan read");

    // no store write while a query is in flight
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.setup || w_cmd.scan) |-> !(w_cmd.load_a || w_cmd.load_b))
        else $error("pixel load during query");

endmodule
